### sv/spos_pkg.sv
// ----------------------------------------------------------------------------
// spos_pkg
// Types and codes shared by the sweep-and-prune open set and its storage.
// ----------------------------------------------------------------------------
package spos_pkg;

    // Width of the entry count and of the capacity register.
    localparam int CNT_W = 7;

    // Request codes.
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Status codes.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_EMPTY   = 2'd2;
    localparam logic [1:0] STS_MISSING = 2'd3;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] MAX_LEN_RST = 7'd64;

    // Input beat.
    typedef struct packed {
        logic [1:0]          req_type;
        logic [15:0]         object_key;
        logic signed [31:0]  z_low;
        logic signed [31:0]  z_high;
        logic signed [31:0]  y_low;
        logic signed [31:0]  y_high;
    } t_req;

    // Result beat.
    typedef struct packed {
        logic                pair_found;
        logic [15:0]         key_new;
        logic [15:0]         key_open;
        logic [CNT_W-1:0]    open_count;
        logic [1:0]          status;
        logic                last;
    } t_rsp;

    // One stored entry.
    typedef struct packed {
        logic [15:0]         key;
        logic signed [31:0]  z_low;
        logic signed [31:0]  z_high;
        logic signed [31:0]  y_low;
        logic signed [31:0]  y_high;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP_RD,
        ST_POP_MV,
        ST_FLUSH
    } t_state;

endpackage

### sv/spos_ram.sv
// ----------------------------------------------------------------------------
// spos_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spos_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sweep_prune_open_set.sv
// ----------------------------------------------------------------------------
// sweep_prune_open_set
// Open set of a sweep-and-prune broad phase: push, pop by key, overlap query.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   Every result beat is shown on o_rsp for exactly one cycle with o_valid
//   high; the receiver has no way to stall, so results are never held back.
//   A push answers in the cycle after it is taken and leaves busy low, so
//   pushes can be issued every cycle. Unknown requests and requests on an
//   empty set also answer in the cycle after they are taken.
//   A pop walks the stored keys through the single RAM read port, one entry
//   per cycle: a hit reads the last entry (ST_POP_RD) and moves it into the
//   freed slot (ST_POP_MV), a miss answers STS_MISSING after the last entry.
//   A query walks all count entries the same way; each pair beat is held back
//   until the next overlap, and the final beat, marked last, carries any held
//   pair. One compare unit checks one entry per cycle; the walk sets the rate.
//   The user must write capacity through i_cfg_we/i_cfg_data while idle; the
//   block does not check it. Synchronous reset empties the set and restores
//   a capacity of 64; the stored entries themselves are not cleared.
// ----------------------------------------------------------------------------
module sweep_prune_open_set #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  spos_pkg::t_req                      i_req,
    input  logic                                i_cfg_we,
    input  logic [spos_pkg::CNT_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output spos_pkg::t_rsp                      o_rsp
);

    localparam int CW = spos_pkg::CNT_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = $bits(spos_pkg::t_entry);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    spos_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_max_len;
    spos_pkg::t_req   r_req, n_req;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_chk_vld, n_chk_vld;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_pend, n_pend;
    logic [15:0]      r_pend_key, n_pend_key;
    logic             r_valid, n_valid;
    spos_pkg::t_rsp   r_rsp, n_rsp;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    spos_pkg::t_entry ram_wdata;
    spos_pkg::t_entry ram_rdata;
    logic [EW-1:0]    ram_rdata_raw;

    logic             accept;
    logic             full;
    logic             key_hit;
    logic             overlap;
    logic             at_end;
    logic [CW-1:0]    count_m1;

    // Entry storage.
    spos_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = spos_pkg::t_entry'(ram_rdata_raw);

    // Shared compare unit: key match and two-axis overlap of the entry read.
    assign key_hit  = (ram_rdata.key == r_req.object_key);
    assign overlap  = (r_req.z_low <= ram_rdata.z_high) && (ram_rdata.z_low <= r_req.z_high) &&
                      (r_req.y_low <= ram_rdata.y_high) && (ram_rdata.y_low <= r_req.y_high);
    assign count_m1 = r_count - CW'(1);
    assign at_end   = (CW'(r_chk_idx) == count_m1);
    assign accept   = start && (r_state == spos_pkg::ST_IDLE);
    assign full     = (r_count >= r_max_len) || (r_count >= DEPTH_C);

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= spos_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spos_pkg::ST_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_pend    <= n_pend;
            r_valid   <= n_valid;
        end
    end

    // Payload and index registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_chk_idx  <= n_chk_idx;
        r_hit_idx  <= n_hit_idx;
        r_pend_key <= n_pend_key;
        r_rsp      <= n_rsp;
    end

    // Sequencer: next state, RAM access and result beats.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_req      = r_req;
        n_addr     = r_addr;
        n_chk_vld  = 1'b0;
        n_chk_idx  = r_addr[AW-1:0];
        n_hit_idx  = r_hit_idx;
        n_pend     = r_pend;
        n_pend_key = r_pend_key;
        n_valid    = 1'b0;
        n_rsp      = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_count[AW-1:0];
        ram_raddr  = r_addr[AW-1:0];
        ram_wdata.key    = i_req.object_key;
        ram_wdata.z_low  = i_req.z_low;
        ram_wdata.z_high = i_req.z_high;
        ram_wdata.y_low  = i_req.y_low;
        ram_wdata.y_high = i_req.y_high;

        unique case (r_state)
            spos_pkg::ST_IDLE: begin
                if (accept) begin
                    n_req  = i_req;
                    n_addr = '0;
                    n_pend = 1'b0;
                    n_rsp.last = 1'b1;
                    n_rsp.open_count = r_count;
                    priority if (i_req.req_type == spos_pkg::REQ_PUSH) begin
                        n_valid = 1'b1;
                        if (full) begin
                            n_rsp.status = spos_pkg::STS_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_rsp.open_count = r_count + CW'(1);
                        end
                    end else if (i_req.req_type == spos_pkg::REQ_POP) begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_rsp.status = spos_pkg::STS_EMPTY;
                        end else begin
                            n_state = spos_pkg::ST_SCAN;
                        end
                    end else if (i_req.req_type == spos_pkg::REQ_QUERY) begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                        end else begin
                            n_state = spos_pkg::ST_SCAN;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end

            spos_pkg::ST_SCAN: begin
                // Issue the next read while entries remain.
                if (r_addr < r_count) begin
                    n_chk_vld = 1'b1;
                    n_addr    = r_addr + CW'(1);
                end
                // Check the entry read in the previous cycle.
                if (r_chk_vld) begin
                    n_rsp.open_count = r_count;
                    if (r_req.req_type == spos_pkg::REQ_POP) begin
                        if (key_hit) begin
                            n_hit_idx = r_chk_idx;
                            n_chk_vld = 1'b0;
                            n_state   = spos_pkg::ST_POP_RD;
                        end else if (at_end) begin
                            n_chk_vld    = 1'b0;
                            n_valid      = 1'b1;
                            n_rsp.status = spos_pkg::STS_MISSING;
                            n_rsp.last   = 1'b1;
                            n_state      = spos_pkg::ST_IDLE;
                        end
                    end else begin
                        // Hold one pair back so the final one can carry last.
                        if (overlap) begin
                            if (r_pend) begin
                                n_valid          = 1'b1;
                                n_rsp.pair_found = 1'b1;
                                n_rsp.key_new    = r_req.object_key;
                                n_rsp.key_open   = r_pend_key;
                            end
                            n_pend     = 1'b1;
                            n_pend_key = ram_rdata.key;
                        end
                        if (at_end) begin
                            n_chk_vld = 1'b0;
                            n_state   = spos_pkg::ST_FLUSH;
                        end
                    end
                end
            end

            spos_pkg::ST_POP_RD: begin
                // Fetch the last entry to fill the freed slot.
                ram_raddr = count_m1[AW-1:0];
                n_state   = spos_pkg::ST_POP_MV;
            end

            spos_pkg::ST_POP_MV: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = ram_rdata;
                n_count   = count_m1;
                n_valid   = 1'b1;
                n_rsp.open_count = count_m1;
                n_rsp.last = 1'b1;
                n_state   = spos_pkg::ST_IDLE;
            end

            spos_pkg::ST_FLUSH: begin
                n_valid          = 1'b1;
                n_rsp.open_count = r_count;
                n_rsp.last       = 1'b1;
                if (r_pend) begin
                    n_rsp.pair_found = 1'b1;
                    n_rsp.key_new    = r_req.object_key;
                    n_rsp.key_open   = r_pend_key;
                end
                n_pend  = 1'b0;
                n_state = spos_pkg::ST_IDLE;
            end

            default: begin
                n_state = spos_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != spos_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // The count never passes the storage depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    // An accepted push that fits grows the count by one and answers next cycle.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.req_type == spos_pkg::REQ_PUSH) && !full
        |=> o_valid && (r_count == $past(r_count) + CW'(1)))
        else $error("push did not append");

    // Every accepted request either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid || busy)
        else $error("request dropped");

    // The beat marked last always leaves the sequencer idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.last |-> !busy)
        else $error("last beat while busy");

    // A pair beat comes only from a query.
    a_pair_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.pair_found |-> (r_req.req_type == spos_pkg::REQ_QUERY))
        else $error("pair beat outside a query");

endmodule
